// ===== design/strm_pkg.sv =====
// ----------------------------------------------------------------------------
// strm_pkg
// Shared types and constants for the sparse-table range-minimum block.
// ----------------------------------------------------------------------------
`default_nettype none

package strm_pkg;

    // default sizing
    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_LEVELS       = 11;
    localparam int DEF_VALUE_WIDTH  = 32;

    // fixed field widths on the stream ports
    localparam int IDX_FIELD_W  = 10;
    localparam int VAL_FIELD_W  = 32;
    localparam int IN_TDATA_W   = 56;   // value, left_index, right_index, padded
    localparam int OUT_TDATA_W  = 48;   // min_index, min_value, padded

    // action codes (slave tuser)
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // status codes (master tuser)
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_Q_TAB,   // query: table read in flight
        ST_Q_VAL,   // query: value read in flight
        ST_Q_OUT,   // query: compare and hand to output register
        ST_B_TAB,   // build: table read in flight
        ST_B_VAL,   // build: value read in flight
        ST_B_WR     // build: compare and write table entry
    } t_state;

endpackage

`default_nettype wire

// ===== design/sparse_table_range_min.sv =====
// ----------------------------------------------------------------------------
// sparse_table_range_min
// Sparse-table range-minimum unit: loads a value store, builds the min-index
// table level by level through one shared compare unit, answers range queries.
// ----------------------------------------------------------------------------
// Loads are taken back to back. A last load of two or more elements starts the
//   build: each entry of level k >= 1 (n - 2^k + 1 of them) takes a table read, a
//   value read and a write, input not ready meanwhile. A query takes a table read,
//   a value read and an output step (bad range: that only), then input is ready.
// Reset (i_rst_n low, synchronous): element count and table-ready cleared,
//   output empty, sequencer idle. Stores are not cleared.
`default_nettype none

module sparse_table_range_min #(
    parameter int MAX_ELEMENTS = strm_pkg::DEF_MAX_ELEMENTS,
    parameter int LEVELS       = strm_pkg::DEF_LEVELS,
    parameter int VALUE_WIDTH  = strm_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [31:0] value, [41:32] left_index, [51:42] right_index, [55:52] zero
    input  wire logic [strm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] action
    input  wire logic                             s_axis_tuser,
    input  wire logic                             s_axis_tlast,   // is_last

    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [9:0] min_index, [41:10] min_value, [47:42] zero
    output logic [strm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] status
    output logic                                  m_axis_tuser
);

    localparam int IDX_W     = $clog2(MAX_ELEMENTS);
    localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int TAB_AW    = LVL_W + IDX_W;
    localparam int TAB_DEPTH = LEVELS * (1 << IDX_W);
    localparam int WW_A      = (CNT_W > LEVELS) ? CNT_W : LEVELS;
    localparam int WW        = ((WW_A > strm_pkg::IDX_FIELD_W + 1) ?
                                WW_A : strm_pkg::IDX_FIELD_W + 1) + 1;

    // ---------------- storage ----------------
    logic        [IDX_W-1:0]       r_tab_mem [TAB_DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_val_mem [MAX_ELEMENTS];

    // ---------------- control registers ----------------
    strm_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_tbl_ready, n_tbl_ready;
    logic              r_out_valid, n_out_valid;

    // ---------------- datapath registers ----------------
    logic [LVL_W-1:0]              r_k, n_k;
    logic [IDX_W-1:0]              r_i, n_i;
    logic [TAB_AW-1:0]             r_ta_a, n_ta_a;
    logic [TAB_AW-1:0]             r_ta_b, n_ta_b;
    logic                          r_bad, n_bad;
    logic [IDX_W-1:0]              r_tq_a, r_tq_b;
    logic signed [VALUE_WIDTH-1:0] r_vq_a, r_vq_b;
    logic [strm_pkg::IDX_FIELD_W-1:0] r_out_idx;
    logic [strm_pkg::VAL_FIELD_W-1:0] r_out_val;
    logic                          r_out_status;

    // ---------------- input fields ----------------
    logic                                    in_acc;
    logic                                    in_action;
    logic                                    in_last;
    logic signed [strm_pkg::VAL_FIELD_W-1:0] in_value;
    logic [strm_pkg::IDX_FIELD_W-1:0]        in_left;
    logic [strm_pkg::IDX_FIELD_W-1:0]        in_right;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign in_action = s_axis_tuser;
    assign in_last   = s_axis_tlast;
    assign in_value  = s_axis_tdata[31:0];
    assign in_left   = s_axis_tdata[41:32];
    assign in_right  = s_axis_tdata[51:42];

    // ---------------- shared compare unit ----------------
    logic                          w_b_wins;
    logic [IDX_W-1:0]              w_win_idx;
    logic signed [VALUE_WIDTH-1:0] w_win_val;

    always_comb begin
        w_b_wins  = r_vq_b < r_vq_a;   // ties keep the left entry
        w_win_idx = w_b_wins ? r_tq_b : r_tq_a;
        w_win_val = w_b_wins ? r_vq_b : r_vq_a;
    end

    // ---------------- query decode ----------------
    logic [WW-1:0]    q_left, q_right, q_len, q_bstart;
    logic [LVL_W-1:0] q_k;
    logic             q_ok;

    always_comb begin
        q_left  = WW'(in_left);
        q_right = WW'(in_right);
        q_ok    = r_tbl_ready && (q_left <= q_right) && (q_right < WW'(r_count));
        q_len   = q_right - q_left + WW'(1);
        q_k     = '0;
        // floor log2 of the length, clamped to the top level
        for (int j = 1; j < LEVELS; j++) begin
            if ((q_len >> j) != '0) begin
                q_k = LVL_W'(j);
            end
        end
        q_bstart = q_right + WW'(1) - (WW'(1) << q_k);
    end

    // ---------------- load decode ----------------
    logic [CNT_W-1:0] ld_base, ld_cnt;
    logic             ld_room, ld_build;

    always_comb begin
        ld_base  = r_tbl_ready ? '0 : r_count;   // a load after a build restarts
        ld_room  = WW'(ld_base) < WW'(MAX_ELEMENTS);
        ld_cnt   = ld_room ? ld_base + CNT_W'(1) : ld_base;
        ld_build = WW'(ld_cnt) >= WW'(2);
    end

    // ---------------- build stepping ----------------
    logic [WW-1:0] b_i1, b_k1, b_n;
    logic          b_more_i, b_more_k;

    always_comb begin
        b_n      = WW'(r_count);
        b_i1     = WW'(r_i) + WW'(1);
        b_k1     = WW'(r_k) + WW'(1);
        b_more_i = (b_i1 + (WW'(1) << r_k)) <= b_n;
        b_more_k = (b_k1 < WW'(LEVELS)) && ((WW'(1) << b_k1) <= b_n);
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            strm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (in_action == strm_pkg::ACT_QUERY) begin
                        n_state = q_ok ? strm_pkg::ST_Q_TAB : strm_pkg::ST_Q_OUT;
                    end else if (in_last && ld_build) begin
                        n_state = strm_pkg::ST_B_TAB;
                    end
                end
            end
            strm_pkg::ST_Q_TAB: n_state = strm_pkg::ST_Q_VAL;
            strm_pkg::ST_Q_VAL: n_state = strm_pkg::ST_Q_OUT;
            strm_pkg::ST_Q_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = strm_pkg::ST_IDLE;
                end
            end
            strm_pkg::ST_B_TAB: n_state = strm_pkg::ST_B_VAL;
            strm_pkg::ST_B_VAL: n_state = strm_pkg::ST_B_WR;
            strm_pkg::ST_B_WR: begin
                if (!b_more_i && !b_more_k) begin
                    n_state = strm_pkg::ST_IDLE;
                end else begin
                    n_state = strm_pkg::ST_B_TAB;
                end
            end
            default: n_state = strm_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs and store writes ----------------
    logic                          out_load;
    logic                          tab_we, val_we;
    logic [TAB_AW-1:0]             tab_wa;
    logic [IDX_W-1:0]              tab_wd;
    logic [IDX_W-1:0]              val_wa;
    logic signed [VALUE_WIDTH-1:0] val_wd;

    always_comb begin
        s_axis_tready = (r_state == strm_pkg::ST_IDLE);
        out_load      = (r_state == strm_pkg::ST_Q_OUT) && (!r_out_valid || m_axis_tready);
        val_we        = 1'b0;
        val_wa        = ld_base[IDX_W-1:0];
        val_wd        = VALUE_WIDTH'(in_value);
        tab_we        = 1'b0;
        tab_wa        = {LVL_W'(0), ld_base[IDX_W-1:0]};
        tab_wd        = ld_base[IDX_W-1:0];
        case (r_state)
            strm_pkg::ST_IDLE: begin
                // level 0 of the table is written as each element arrives
                if (in_acc && (in_action == strm_pkg::ACT_LOAD) && ld_room) begin
                    val_we = 1'b1;
                    tab_we = 1'b1;
                end
            end
            strm_pkg::ST_B_WR: begin
                tab_we = 1'b1;
                tab_wa = {r_k, r_i};
                tab_wd = w_win_idx;
            end
            default: begin
                tab_we = 1'b0;
            end
        endcase
        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = {6'b0, r_out_val, r_out_idx};
        m_axis_tuser  = r_out_status;
    end

    // ---------------- next values ----------------
    always_comb begin
        n_count     = r_count;
        n_tbl_ready = r_tbl_ready;
        n_out_valid = r_out_valid;
        n_k         = r_k;
        n_i         = r_i;
        n_ta_a      = r_ta_a;
        n_ta_b      = r_ta_b;
        n_bad       = r_bad;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end

        case (r_state)
            strm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (in_action == strm_pkg::ACT_QUERY) begin
                        n_bad  = !q_ok;
                        n_ta_a = {q_k, q_left[IDX_W-1:0]};
                        n_ta_b = {q_k, q_bstart[IDX_W-1:0]};
                    end else begin
                        n_count     = ld_cnt;
                        n_tbl_ready = in_last && !ld_build;
                        n_k         = LVL_W'(1);
                        n_i         = '0;
                        n_ta_a      = {LVL_W'(0), IDX_W'(0)};
                        n_ta_b      = {LVL_W'(0), IDX_W'(1)};
                    end
                end
            end
            strm_pkg::ST_B_WR: begin
                if (b_more_i) begin
                    n_i    = b_i1[IDX_W-1:0];
                    n_ta_a = {r_k - LVL_W'(1), b_i1[IDX_W-1:0]};
                    n_ta_b = {r_k - LVL_W'(1),
                              IDX_W'(b_i1 + (WW'(1) << (r_k - LVL_W'(1))))};
                end else if (b_more_k) begin
                    n_k    = b_k1[LVL_W-1:0];
                    n_i    = '0;
                    n_ta_a = {r_k, IDX_W'(0)};
                    n_ta_b = {r_k, IDX_W'(WW'(1) << r_k)};
                end else begin
                    n_tbl_ready = 1'b1;
                end
            end
            default: begin
                n_bad = r_bad;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= strm_pkg::ST_IDLE;
            r_count     <= '0;
            r_tbl_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_tbl_ready <= n_tbl_ready;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_i    <= n_i;
        r_ta_a <= n_ta_a;
        r_ta_b <= n_ta_b;
        r_bad  <= n_bad;
        if (out_load) begin
            if (r_bad) begin
                r_out_idx    <= '0;
                r_out_val    <= '0;
                r_out_status <= strm_pkg::STATUS_BAD;
            end else begin
                r_out_idx    <= strm_pkg::IDX_FIELD_W'(w_win_idx);
                r_out_val    <= strm_pkg::VAL_FIELD_W'(w_win_val);
                r_out_status <= strm_pkg::STATUS_OK;
            end
        end
    end

    // table store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[tab_wa] <= tab_wd;
        end
        r_tq_a <= r_tab_mem[r_ta_a];
        r_tq_b <= r_tab_mem[r_ta_b];
    end

    // value store, addressed by the table read data
    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[val_wa] <= val_wd;
        end
        r_vq_a <= r_val_mem[r_tq_a];
        r_vq_b <= r_val_mem[r_tq_b];
    end

    // ---------------- assertions ----------------
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == strm_pkg::ST_Q_OUT))
        else $error("result appeared outside the output step");

    a_build_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == strm_pkg::ST_B_WR) |-> (r_k != '0))
        else $error("build wrote level 0");

    a_build_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == strm_pkg::ST_B_WR) |->
            ((WW'(r_i) + (WW'(1) << r_k)) <= WW'(r_count)))
        else $error("build entry beyond loaded elements");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_count) <= WW'(MAX_ELEMENTS))
        else $error("element count overflow");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sparse_table_range_min. Loads and range-minimum
// queries are queued up front; a clocked driver and monitor move them across
// the two streams with random gaps. Every answer is checked against a
// behavioural copy of the value store that scans for the leftmost minimum.
// ----------------------------------------------------------------------------

module testbench;

    localparam int IDX_FIELD_W  = strm_pkg::IDX_FIELD_W;
    localparam int VAL_FIELD_W  = strm_pkg::VAL_FIELD_W;
    localparam int IN_TDATA_W   = strm_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W  = strm_pkg::OUT_TDATA_W;

    localparam int CAP          = strm_pkg::DEF_MAX_ELEMENTS;
    localparam int RANDOM_ITEMS = 1500;
    localparam int IDLE_LIMIT   = 100000;  // must exceed the longest build, when no item moves
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_MAX   = 10;
    localparam int PAD_W        = IN_TDATA_W - 2 * IDX_FIELD_W - VAL_FIELD_W;

    typedef enum int {VALS_WIDE, VALS_NARROW, VALS_EDGES} t_value_mix;

    typedef struct {
        logic                        action;
        logic signed [VAL_FIELD_W-1:0] value;
        logic                        last;
        logic [IDX_FIELD_W-1:0]      lo_idx;
        logic [IDX_FIELD_W-1:0]      hi_idx;
        bit                          hold;    // wait until all answers are in
    } t_rmq_item;

    typedef struct {
        logic [IDX_FIELD_W-1:0]        min_idx;
        logic signed [VAL_FIELD_W-1:0] min_val;
        logic                          status;
    } t_range_min;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = strm_pkg::ACT_LOAD;
    logic                   s_axis_tlast  = 1'b0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    sparse_table_range_min DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // behavioural store and answers awaited from the block
    // ------------------------------------------------------------------------
    logic signed [VAL_FIELD_W-1:0] store_vals [CAP];
    int                            store_count = 0;
    bit                            store_built = 1'b0;

    t_rmq_item  pending_items[$];
    t_range_min awaited_minima[$];

    int error_count = 0;
    int ok_answers  = 0;
    int bad_answers = 0;

    function automatic void update_store_or_answer(t_rmq_item it);
        t_range_min ans;
        int best;
        if (it.action == strm_pkg::ACT_LOAD) begin
            if (store_built) begin
                store_built = 1'b0;
                store_count = 0;
            end
            if (store_count < CAP) begin
                store_vals[store_count] = it.value;
                store_count++;
            end
            if (it.last)
                store_built = 1'b1;
        end else begin
            ans = '{min_idx: '0, min_val: '0, status: strm_pkg::STATUS_BAD};
            if (store_built && it.lo_idx <= it.hi_idx && int'(it.hi_idx) < store_count) begin
                best = int'(it.lo_idx);
                // strict compare keeps the leftmost of equal values
                for (int i = int'(it.lo_idx) + 1; i <= int'(it.hi_idx); i++)
                    if (store_vals[i] < store_vals[best])
                        best = i;
                ans.min_idx = best[IDX_FIELD_W-1:0];
                ans.min_val = store_vals[best];
                ans.status  = strm_pkg::STATUS_OK;
            end
            awaited_minima.push_back(ans);
        end
    endfunction

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("ERROR: %s", msg);
    endtask

    // mostly a short random gap, now and then a run of back-to-back items
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------------
    int queued_items  = 0;
    int n_loads       = 0;
    int n_queries     = 0;
    int n_builds      = 0;
    int n_dropped     = 0;
    int largest_build = 0;
    int gen_count     = 0;
    bit gen_built     = 1'b0;

    task automatic add_load(logic signed [VAL_FIELD_W-1:0] v, logic last, bit hold);
        t_rmq_item it;
        it = '{action: strm_pkg::ACT_LOAD, value: v, last: last,
               lo_idx: IDX_FIELD_W'($urandom), hi_idx: IDX_FIELD_W'($urandom),
               hold: hold};
        pending_items.push_back(it);
        queued_items++;
        n_loads++;
        if (gen_built) begin
            gen_built = 1'b0;
            gen_count = 0;
        end
        if (gen_count < CAP)
            gen_count++;
        else
            n_dropped++;
        if (last) begin
            gen_built = 1'b1;
            n_builds++;
            if (gen_count > largest_build)
                largest_build = gen_count;
        end
    endtask

    task automatic add_query(int lo, int hi, logic last, bit hold);
        t_rmq_item it;
        it = '{action: strm_pkg::ACT_QUERY, value: $urandom, last: last,
               lo_idx: lo[IDX_FIELD_W-1:0], hi_idx: hi[IDX_FIELD_W-1:0], hold: hold};
        pending_items.push_back(it);
        queued_items++;
        n_queries++;
    endtask

    function automatic logic signed [VAL_FIELD_W-1:0] pick_value(t_value_mix mix);
        case (mix)
            VALS_WIDE:   return $urandom;
            VALS_NARROW: return int'($urandom_range(0, 6)) - 3;  // plenty of ties
            default: begin
                case ($urandom_range(0, 4))
                    0:       return {1'b1, {(VAL_FIELD_W-1){1'b0}}};
                    1:       return {1'b0, {(VAL_FIELD_W-1){1'b1}}};
                    2:       return '0;
                    3:       return '1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic add_random_query();
        int lo, hi, cnt;
        logic last;
        last = ($urandom_range(0, 3) == 0);
        cnt  = gen_count;
        if (!gen_built || cnt == 0) begin
            add_query($urandom_range(0, 1023), $urandom_range(0, 1023), last, 1'b0);
            return;
        end
        case ($urandom_range(0, 19))
            12, 13: begin
                lo = $urandom_range(0, cnt - 1);
                hi = lo + $urandom_range(0, 15);
                if (hi > cnt - 1)
                    hi = cnt - 1;
            end
            14: begin
                lo = 0;
                hi = cnt - 1;
            end
            15: begin
                lo = $urandom_range(1, 1023);
                hi = $urandom_range(0, lo - 1);
            end
            16: begin
                hi = (cnt < CAP) ? $urandom_range(cnt, 1023) : $urandom_range(0, 1023);
                lo = $urandom_range(0, hi);
            end
            17, 18, 19: begin
                lo = $urandom_range(0, 1023);
                hi = $urandom_range(0, 1023);
            end
            default: begin
                lo = $urandom_range(0, cnt - 1);
                hi = $urandom_range(lo, cnt - 1);
            end
        endcase
        add_query(lo, hi, last, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    t_rmq_item offer_item;
    bit        offering  = 1'b0;
    int        send_gap  = 0;
    int        send_calm = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offering = 1'b0;
            send_gap = 0;
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                update_store_or_answer(offer_item);
                offering = 1'b0;
                send_gap = draw_gap(send_calm);
            end
            if (!offering) begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_items.size() != 0 &&
                         (!pending_items[0].hold || awaited_minima.size() == 0)) begin
                    offer_item = pending_items.pop_front();
                    offering   = 1'b1;
                    s_axis_tdata <= {{PAD_W{1'b0}}, offer_item.hi_idx,
                                     offer_item.lo_idx, offer_item.value};
                    s_axis_tuser <= offer_item.action;
                    s_axis_tlast <= offer_item.last;
                end
            end
            s_axis_tvalid <= offering;
        end
    end

    // ------------------------------------------------------------------------
    // monitor and checker
    // ------------------------------------------------------------------------
    int recv_gap  = 0;
    int recv_calm = 0;

    always @(posedge i_clk) begin : monitor_proc
        bit                            ready_now;
        t_range_min                    want;
        logic [IDX_FIELD_W-1:0]        got_idx;
        logic signed [VAL_FIELD_W-1:0] got_val;
        ready_now = m_axis_tready;
        if (!i_rst_n) begin
            recv_gap  = 0;
            ready_now = 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            got_idx = m_axis_tdata[IDX_FIELD_W-1:0];
            got_val = $signed(m_axis_tdata[IDX_FIELD_W +: VAL_FIELD_W]);
            if (m_axis_tuser == strm_pkg::STATUS_OK)
                ok_answers++;
            else
                bad_answers++;
            if (awaited_minima.size() == 0) begin
                note_error($sformatf("unexpected item: idx %0d value %0d status %0d",
                                     got_idx, got_val, m_axis_tuser));
            end else begin
                want = awaited_minima.pop_front();
                if (got_idx !== want.min_idx || got_val !== want.min_val ||
                    m_axis_tuser !== want.status)
                    note_error($sformatf(
                        "expected idx %0d value %0d status %0d, got idx %0d value %0d status %0d",
                        want.min_idx, want.min_val, want.status,
                        got_idx, got_val, m_axis_tuser));
            end
            recv_gap  = draw_gap(recv_calm);
            ready_now = (recv_gap == 0);
        end else if (!m_axis_tready) begin
            if (recv_gap > 0)
                recv_gap--;
            ready_now = (recv_gap == 0);
        end
        m_axis_tready <= ready_now;
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles in which neither stream moves an item
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d answers outstanding",
                     idle_cycles, awaited_minima.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int         n, nq, directed_items, phase_no;
        t_value_mix mix;
        bit         broken, hold_first, big;

        // no table yet
        add_query(0, 0, 1'b0, 1'b1);
        add_query(5, 3, 1'b0, 1'b0);
        add_load({1'b1, {(VAL_FIELD_W-1){1'b0}}}, 1'b0, 1'b0);
        add_load({1'b0, {(VAL_FIELD_W-1){1'b1}}}, 1'b0, 1'b0);
        add_query(0, 1, 1'b0, 1'b0);                   // mid-load, still unbuilt
        add_load(0, 1'b0, 1'b0);
        add_load(-1, 1'b0, 1'b0);
        add_load(-1, 1'b0, 1'b0);
        add_load(7, 1'b1, 1'b0);
        add_query(0, 5, 1'b0, 1'b0);
        add_query(1, 5, 1'b0, 1'b0);                   // tie, left one wins
        add_query(4, 4, 1'b0, 1'b0);
        add_query(3, 4, 1'b0, 1'b0);
        add_query(2, 1, 1'b0, 1'b0);                   // left beyond right
        add_query(0, 6, 1'b0, 1'b0);                   // past element count
        add_query(1023, 1023, 1'b0, 1'b0);
        add_query(0, 5, 1'b1, 1'b0);                   // tlast on a query is ignored
        // a load after a build restarts the sequence
        add_load(5, 1'b1, 1'b1);
        add_query(0, 0, 1'b0, 1'b0);
        add_query(0, 1, 1'b0, 1'b0);
        add_load({1'b0, {(VAL_FIELD_W-1){1'b1}}}, 1'b0, 1'b1);
        add_load({1'b0, {(VAL_FIELD_W-1){1'b1}}}, 1'b1, 1'b0);
        add_query(0, 1, 1'b0, 1'b0);
        add_query(1, 1, 1'b0, 1'b0);
        directed_items = queued_items;

        phase_no  = 0;
        while (queued_items - directed_items < RANDOM_ITEMS) begin
            big  = (phase_no == 2);   // one pass that overfills the store
            if (big)
                n = CAP + $urandom_range(1, 8);
            else if ($urandom_range(0, 7) == 0)
                n = $urandom_range(64, 300);
            else
                n = $urandom_range(1, 40);
            mix        = t_value_mix'($urandom_range(0, 2));
            broken     = !big && ($urandom_range(0, 7) == 0);
            hold_first = ($urandom_range(0, 4) == 0);
            for (int j = 0; j < n; j++) begin
                if (!big && $urandom_range(0, 29) == 0)
                    add_random_query();
                add_load(pick_value(mix), (j == n - 1) && !broken, (j == 0) && hold_first);
            end
            nq = big ? 80 : $urandom_range(2, 24);
            for (int j = 0; j < nq; j++)
                add_random_query();
            phase_no++;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || offering || awaited_minima.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d loads in %0d builds (largest %0d elements, %0d dropped when full)",
                 n_loads, n_builds, largest_build, n_dropped);
        $display("and %0d queries: %0d answered in range, %0d flagged bad, %0d mismatches",
                 n_queries, ok_answers, bad_answers, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
